### sv/bfa_pkg.sv
// Package for the bitmap frame allocator: sizes, codes and the control store.
package bfa_pkg;

  localparam int MAX_FRAMES  = 32768;
  localparam int WORD_BITS   = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 16;
  localparam int NUM_WORDS   = MAX_FRAMES / WORD_BITS;
  localparam int WIDX_W      = $clog2(NUM_WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int FIDX_W      = WIDX_W + BIT_W;
  localparam int FNUM_W      = ADDR_W - FRAME_SHIFT;
  localparam int NW_W        = $clog2(NUM_WORDS + 1);
  localparam int PC_W        = 5;

  localparam logic [CNT_W-1:0]     FRAME_COUNT_RST = CNT_W'(32768);
  localparam logic [WORD_BITS-1:0] ALL_USED        = {WORD_BITS{1'b1}};

  // Operation codes
  localparam logic [1:0] FN_ALLOC    = 2'd0;
  localparam logic [1:0] FN_FREE     = 2'd1;
  localparam logic [1:0] FN_REG_FREE = 2'd2;
  localparam logic [1:0] FN_REG_USED = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE      = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef logic [PC_W-1:0] pc_t;

  // Step addresses of the control program
  localparam pc_t P_CLR    = 5'd0;
  localparam pc_t P_IDLE   = 5'd1;
  localparam pc_t P_DEC    = 5'd2;
  localparam pc_t P_DEC2   = 5'd3;
  localparam pc_t P_A0     = 5'd4;
  localparam pc_t P_A1     = 5'd5;
  localparam pc_t P_A2     = 5'd6;
  localparam pc_t P_A3     = 5'd7;
  localparam pc_t P_A4     = 5'd8;
  localparam pc_t P_F0     = 5'd9;
  localparam pc_t P_F1     = 5'd10;
  localparam pc_t P_FNA    = 5'd11;
  localparam pc_t P_F2     = 5'd12;
  localparam pc_t P_R0     = 5'd13;
  localparam pc_t P_R1     = 5'd14;
  localparam pc_t P_R2     = 5'd15;
  localparam pc_t P_RCNT   = 5'd16;
  localparam pc_t P_RZ0    = 5'd17;
  localparam pc_t P_RZ1    = 5'd18;
  localparam pc_t P_DONE   = 5'd19;

  typedef enum logic [3:0] {
    A_NOP,
    A_CLR,
    A_IDLE,
    A_DECODE,
    A_RD_INC,
    A_SCAN,
    A_ALLOC_WR,
    A_FREE_RD,
    A_FREE_WR,
    A_NOT_ALLOC,
    A_REG_RD,
    A_REG_WR,
    A_REG_CNT,
    A_ZERO_RD,
    A_ZERO_WR,
    A_DONE
  } act_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_CLR_MORE,
    C_START,
    C_IS_ALLOC,
    C_IS_FREE,
    C_ALLOC_SKIP,
    C_SCAN_STOP,
    C_HIT,
    C_FREE_OOR,
    C_BIT_SET,
    C_K_LT_STOP,
    C_NEXT_LT_STOP,
    C_IS_REG_FREE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   tgt_t;
    pc_t   tgt_f;
  } ucw_t;

  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    unique case (pc)
      P_CLR:   w = '{A_CLR,       C_CLR_MORE,     P_CLR,  P_IDLE};
      P_IDLE:  w = '{A_IDLE,      C_START,        P_DEC,  P_IDLE};
      P_DEC:   w = '{A_DECODE,    C_IS_ALLOC,     P_A0,   P_DEC2};
      P_DEC2:  w = '{A_NOP,       C_IS_FREE,      P_F0,   P_R0};
      P_A0:    w = '{A_NOP,       C_ALLOC_SKIP,   P_DONE, P_A1};
      P_A1:    w = '{A_RD_INC,    C_ALWAYS,       P_A2,   P_A2};
      P_A2:    w = '{A_SCAN,      C_SCAN_STOP,    P_A3,   P_A2};
      P_A3:    w = '{A_NOP,       C_HIT,          P_A4,   P_DONE};
      P_A4:    w = '{A_ALLOC_WR,  C_ALWAYS,       P_DONE, P_DONE};
      P_F0:    w = '{A_FREE_RD,   C_FREE_OOR,     P_DONE, P_F1};
      P_F1:    w = '{A_NOP,       C_BIT_SET,      P_F2,   P_FNA};
      P_FNA:   w = '{A_NOT_ALLOC, C_ALWAYS,       P_DONE, P_DONE};
      P_F2:    w = '{A_FREE_WR,   C_ALWAYS,       P_DONE, P_DONE};
      P_R0:    w = '{A_NOP,       C_K_LT_STOP,    P_R1,   P_RCNT};
      P_R1:    w = '{A_REG_RD,    C_ALWAYS,       P_R2,   P_R2};
      P_R2:    w = '{A_REG_WR,    C_NEXT_LT_STOP, P_R1,   P_RCNT};
      P_RCNT:  w = '{A_REG_CNT,   C_IS_REG_FREE,  P_RZ0,  P_DONE};
      P_RZ0:   w = '{A_ZERO_RD,   C_ALWAYS,       P_RZ1,  P_RZ1};
      P_RZ1:   w = '{A_ZERO_WR,   C_ALWAYS,       P_DONE, P_DONE};
      P_DONE:  w = '{A_DONE,      C_ALWAYS,       P_IDLE, P_IDLE};
      default: w = '{A_NOP,       C_ALWAYS,       P_IDLE, P_IDLE};
    endcase
    return w;
  endfunction

endpackage

### sv/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: microcoded sequencer, datapath, bitmap memory.
//
// Usage: drive in_func, in_address and in_size_bytes with start high; the
// operation is taken at a rising edge where start is high and busy is low.
// Exactly one result per operation appears on out_frame_address, out_status
// and out_free_frames for one cycle, marked by out_valid. The receiver
// cannot stall; results must be taken in the cycle they are shown.
// cfg_we with cfg_wdata writes frame_count at any edge; write it while idle.
// Steps of each operation (from start transfer to out_valid), with nw the number
// of whole 32-bit words below the frame count:
//   allocate: no scan when the count is zero or nw is zero, else up to nw words
//     (one bitmap word scanned per cycle through the single read port);
//   free: ends after the read when the frame is out of range;
//   region: each bitmap word touched is read, then written, plus
//     the frame-zero fixup (read, then write) of a region free.
// busy drops the cycle out_valid rises, so a new operation may start then.
// Reset: a clearing pass writes every bitmap word to all used, one word per
// cycle; busy stays high until it ends. The free count resets to zero and
// frame_count to 32768.
module bitmap_frame_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_address,
  input  logic [31:0] in_size_bytes,
  output logic        out_valid,
  output logic [31:0] out_frame_address,
  output logic [1:0]  out_status,
  output logic [15:0] out_free_frames,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  pc_t                  pc_r, pc_nxt;
  ucw_t                 uw;
  logic                 cond_true;

  logic [1:0]           func_r, func_nxt;
  logic [FNUM_W-1:0]    f_r, f_nxt;
  logic [FNUM_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]     lim_r, lim_nxt;
  logic [CNT_W-1:0]     stop_r, stop_nxt;
  logic [NW_W-1:0]      nw_r, nw_nxt;
  logic [WIDX_W-1:0]    widx_r, widx_nxt;
  logic [WIDX_W-1:0]    ridx_r, ridx_nxt;
  logic [FNUM_W-1:0]    k_r, k_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [ADDR_W-1:0]    faddr_r, faddr_nxt;
  logic [CNT_W-1:0]     ft_r, ft_nxt;
  logic                 hit_r, hit_nxt;
  logic [WIDX_W-1:0]    hit_word_r, hit_word_nxt;
  logic [BIT_W-1:0]     hit_bit_r, hit_bit_nxt;
  logic [WORD_BITS-1:0] hit_data_r, hit_data_nxt;
  logic [CNT_W-1:0]     fc_r;
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_faddr_r;
  logic [1:0]           out_status_r;
  logic [CNT_W-1:0]     out_ft_r;
  logic [WORD_BITS-1:0] rdata_r;

  logic                 mem_re, mem_we;
  logic [WIDX_W-1:0]    mem_ra, mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  logic [CNT_W-1:0]     lim_in;
  logic [FNUM_W:0]      end_w;
  logic [BIT_W-1:0]     zbit;
  logic                 has_zero;
  logic                 scan_last;
  logic [CNT_W-1:0]     stop_m1;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] reg_mask;
  logic [FNUM_W-1:0]    k_next;
  logic [FNUM_W:0]      ft_sum;
  logic [WIDX_W-1:0]    k_word;

  assign uw = ucode(pc_r);

  assign lim_in = ({16'b0, fc_r} < 32'(MAX_FRAMES)) ? fc_r : CNT_W'(MAX_FRAMES);
  assign end_w  = {1'b0, f_r} + {1'b0, n_r};

  // Lowest clear bit of the word just read
  always_comb begin
    zbit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rdata_r[i]) zbit = BIT_W'(i);
    end
  end
  assign has_zero  = ~&rdata_r;
  assign scan_last = (NW_W'(ridx_r) + NW_W'(1)) == nw_r;

  // Bits of the region that fall in the current word
  assign k_word   = k_r[FIDX_W-1:BIT_W];
  assign stop_m1  = stop_r - CNT_W'(1);
  assign hi_bit   = (stop_m1[FIDX_W-1:BIT_W] == k_word) ? stop_m1[BIT_W-1:0]
                                                         : BIT_W'(WORD_BITS - 1);
  assign reg_mask = (ALL_USED << k_r[BIT_W-1:0])
                  & (ALL_USED >> (BIT_W'(WORD_BITS - 1) - hi_bit));
  assign k_next   = {k_r[FNUM_W-1:BIT_W] + (FNUM_W - BIT_W)'(1), BIT_W'(0)};
  assign ft_sum   = (FNUM_W + 1)'(ft_r) + {1'b0, n_r};

  // Jump condition
  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:       cond_true = 1'b1;
      C_CLR_MORE:     cond_true = widx_r != WIDX_W'(NUM_WORDS - 1);
      C_START:        cond_true = start;
      C_IS_ALLOC:     cond_true = func_r == FN_ALLOC;
      C_IS_FREE:      cond_true = func_r == FN_FREE;
      C_ALLOC_SKIP:   cond_true = (ft_r == '0) || (nw_r == '0);
      C_SCAN_STOP:    cond_true = has_zero || scan_last;
      C_HIT:          cond_true = hit_r;
      C_FREE_OOR:     cond_true = f_r >= FNUM_W'(lim_r);
      C_BIT_SET:      cond_true = rdata_r[f_r[BIT_W-1:0]];
      C_K_LT_STOP:    cond_true = k_r < FNUM_W'(stop_r);
      C_NEXT_LT_STOP: cond_true = k_next < FNUM_W'(stop_r);
      C_IS_REG_FREE:  cond_true = func_r == FN_REG_FREE;
      default:        cond_true = 1'b0;
    endcase
  end

  assign pc_nxt = cond_true ? uw.tgt_t : uw.tgt_f;

  // Datapath controlled by the current control word
  always_comb begin
    func_nxt     = func_r;
    f_nxt        = f_r;
    n_nxt        = n_r;
    lim_nxt      = lim_r;
    stop_nxt     = stop_r;
    nw_nxt       = nw_r;
    widx_nxt     = widx_r;
    ridx_nxt     = ridx_r;
    k_nxt        = k_r;
    status_nxt   = status_r;
    faddr_nxt    = faddr_r;
    ft_nxt       = ft_r;
    hit_nxt      = hit_r;
    hit_word_nxt = hit_word_r;
    hit_bit_nxt  = hit_bit_r;
    hit_data_nxt = hit_data_r;
    mem_re       = 1'b0;
    mem_ra       = widx_r;
    mem_we       = 1'b0;
    mem_wa       = widx_r;
    mem_wd       = ALL_USED;
    unique case (uw.act)
      A_NOP: begin
      end
      A_CLR: begin
        mem_we   = 1'b1;
        widx_nxt = widx_r + WIDX_W'(1);
      end
      A_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          f_nxt    = in_address[ADDR_W-1:FRAME_SHIFT];
          n_nxt    = in_size_bytes[ADDR_W-1:FRAME_SHIFT];
          lim_nxt  = lim_in;
        end
      end
      A_DECODE: begin
        stop_nxt  = (end_w < (FNUM_W + 1)'(lim_r)) ? CNT_W'(end_w) : lim_r;
        nw_nxt    = NW_W'(lim_r >> BIT_W);
        k_nxt     = f_r;
        faddr_nxt = '0;
        hit_nxt   = 1'b0;
        widx_nxt  = (func_r == FN_FREE) ? f_r[FIDX_W-1:BIT_W] : '0;
        priority if (func_r == FN_ALLOC) begin
          status_nxt = ST_NONE;
        end else if (func_r == FN_FREE) begin
          status_nxt = (f_r >= FNUM_W'(lim_r)) ? ST_RANGE : ST_OK;
        end else begin
          status_nxt = ((n_r != '0) && (end_w > (FNUM_W + 1)'(lim_r))) ? ST_RANGE : ST_OK;
        end
      end
      A_RD_INC: begin
        mem_re   = 1'b1;
        ridx_nxt = widx_r;
        widx_nxt = widx_r + WIDX_W'(1);
      end
      A_SCAN: begin
        // check the word read last cycle, fetch the next one
        mem_re       = 1'b1;
        ridx_nxt     = widx_r;
        widx_nxt     = widx_r + WIDX_W'(1);
        hit_nxt      = has_zero;
        hit_word_nxt = ridx_r;
        hit_bit_nxt  = zbit;
        hit_data_nxt = rdata_r | (WORD_BITS'(1) << zbit);
      end
      A_ALLOC_WR: begin
        mem_we     = 1'b1;
        mem_wa     = hit_word_r;
        mem_wd     = hit_data_r;
        ft_nxt     = ft_r - CNT_W'(1);
        faddr_nxt  = ADDR_W'({hit_word_r, hit_bit_r}) << FRAME_SHIFT;
        status_nxt = ST_OK;
      end
      A_FREE_RD: begin
        mem_re = 1'b1;
      end
      A_FREE_WR: begin
        mem_we = 1'b1;
        mem_wd = rdata_r & ~(WORD_BITS'(1) << f_r[BIT_W-1:0]);
        if (ft_r < lim_r) ft_nxt = ft_r + CNT_W'(1);
      end
      A_NOT_ALLOC: begin
        status_nxt = ST_NOT_ALLOC;
      end
      A_REG_RD: begin
        mem_re = 1'b1;
        mem_ra = k_word;
      end
      A_REG_WR: begin
        mem_we = 1'b1;
        mem_wa = k_word;
        mem_wd = (func_r == FN_REG_USED) ? (rdata_r | reg_mask) : (rdata_r & ~reg_mask);
        k_nxt  = k_next;
      end
      A_REG_CNT: begin
        // move the count by the whole region, saturating
        if (func_r == FN_REG_USED) begin
          ft_nxt = (n_r >= FNUM_W'(ft_r)) ? '0 : ft_r - CNT_W'(n_r);
        end else begin
          ft_nxt = (ft_sum > (FNUM_W + 1)'(lim_r)) ? lim_r : CNT_W'(ft_sum);
        end
      end
      A_ZERO_RD: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      A_ZERO_WR: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = rdata_r | WORD_BITS'(1);
      end
      A_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= P_CLR;
      widx_r      <= '0;
      ft_r        <= '0;
      fc_r        <= FRAME_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      widx_r      <= widx_nxt;
      ft_r        <= ft_nxt;
      out_valid_r <= uw.act == A_DONE;
      if (cfg_we) fc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    f_r        <= f_nxt;
    n_r        <= n_nxt;
    lim_r      <= lim_nxt;
    stop_r     <= stop_nxt;
    nw_r       <= nw_nxt;
    ridx_r     <= ridx_nxt;
    k_r        <= k_nxt;
    status_r   <= status_nxt;
    faddr_r    <= faddr_nxt;
    hit_r      <= hit_nxt;
    hit_word_r <= hit_word_nxt;
    hit_bit_r  <= hit_bit_nxt;
    hit_data_r <= hit_data_nxt;
    if (uw.act == A_DONE) begin
      out_faddr_r  <= faddr_r;
      out_status_r <= status_r;
      out_ft_r     <= ft_r;
    end
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  assign busy              = pc_r != P_IDLE;
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_faddr_r;
  assign out_status        = out_status_r;
  assign out_free_frames   = out_ft_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("operation transfer did not raise busy");

  a_addr_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_frame_address == '0))
    else $error("frame address given with a failing status");

  a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_address[FRAME_SHIFT-1:0] == '0))
    else $error("frame address not frame aligned");
`endif

endmodule

### tb/frame_alloc_checker.sv
`timescale 1ns / 100ps
// Checker for the frame allocator: predicts each operation's answer and compares it.
module frame_alloc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_address,
  input  logic [31:0] in_size_bytes,
  input  logic        out_valid,
  input  logic [31:0] out_frame_address,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_free_frames,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import bfa_pkg::*;

  typedef struct packed {
    logic [31:0]      frame_address;
    logic [1:0]       status;
    logic [CNT_W-1:0] free_frames;
  } answer_t;

  logic [WORD_BITS-1:0] frame_used [NUM_WORDS];
  logic [CNT_W-1:0]     free_count;
  logic [CNT_W-1:0]     frame_count;
  answer_t              answer_q [$];
  int                   fails = 0;

  function automatic int unsigned frame_limit();
    return (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
  endfunction

  function automatic void put_frame_bit(int unsigned fr, logic used);
    frame_used[fr / WORD_BITS][fr % WORD_BITS] = used;
  endfunction

  // Apply one operation to the bitmap and count, and return its answer.
  function automatic answer_t run_operation(logic [1:0] fn, logic [31:0] addr,
                                            logic [31:0] size);
    answer_t           a;
    int unsigned       lim;
    int unsigned       fr;
    int unsigned       nfr;
    int unsigned       hit;
    longint unsigned   reg_last;
    longint unsigned   stop;
    longint unsigned   sum;
    bit                found;
    a.frame_address = '0;
    a.status        = ST_OK;
    lim = frame_limit();
    fr  = addr >> FRAME_SHIFT;
    case (fn)
      FN_ALLOC: begin
        a.status = ST_NONE;
        found = 1'b0;
        if (free_count != 0) begin
          // first fit over whole words only
          for (int i = 0; i < lim / WORD_BITS && !found; i++) begin
            if (frame_used[i] != ALL_USED) begin
              for (int j = 0; j < WORD_BITS && !found; j++) begin
                if (!frame_used[i][j]) begin
                  hit = i * WORD_BITS + j;
                  put_frame_bit(hit, 1'b1);
                  free_count      = free_count - 1'b1;
                  a.frame_address = 32'(hit) << FRAME_SHIFT;
                  a.status        = ST_OK;
                  found           = 1'b1;
                end
              end
            end
          end
        end
      end
      FN_FREE: begin
        if (fr >= lim) a.status = ST_RANGE;
        else if (!frame_used[fr / WORD_BITS][fr % WORD_BITS]) a.status = ST_NOT_ALLOC;
        else begin
          put_frame_bit(fr, 1'b0);
          if (free_count < lim) free_count = free_count + 1'b1;
        end
      end
      default: begin
        nfr      = size >> FRAME_SHIFT;
        reg_last = longint'(fr) + nfr;
        stop     = (reg_last < lim) ? reg_last : lim;
        for (longint unsigned k = fr; k < stop; k++) put_frame_bit(int'(k), fn == FN_REG_USED);
        if (nfr != 0 && reg_last > lim) a.status = ST_RANGE;
        // count moves by the whole region, whatever the old bits were
        if (fn == FN_REG_USED) begin
          free_count = (nfr >= free_count) ? '0 : CNT_W'(free_count - nfr);
        end else begin
          sum        = longint'(free_count) + nfr;
          free_count = (sum > lim) ? CNT_W'(lim) : CNT_W'(sum);
          put_frame_bit(0, 1'b1);
        end
      end
    endcase
    a.free_frames = free_count;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) frame_used[i] = ALL_USED;
      free_count  = '0;
      frame_count = FRAME_COUNT_RST;
      answer_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_frame_address, '0);
        end else begin
          want = answer_q.pop_front();
          if (out_frame_address !== want.frame_address)
            report_mismatch("frame_address", out_frame_address, want.frame_address);
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_free_frames !== want.free_frames)
            report_mismatch("free_frames", 32'(out_free_frames), 32'(want.free_frames));
        end
      end
      if (cfg_we === 1'b1) frame_count = cfg_wdata;
      if (start === 1'b1 && busy === 1'b0)
        answer_q.push_back(run_operation(in_func, in_address, in_size_bytes));
    end
    pending    <= answer_q.size();
    fail_count <= fails;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the frame allocator testbench: clock, reset, stimulus and verdict.
module testbench;
  import bfa_pkg::*;

  localparam int QUIET_LIMIT     = 20000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 95;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [31:0] in_address;
  logic [31:0] in_size_bytes;
  logic        out_valid;
  logic [31:0] out_frame_address;
  logic [1:0]  out_status;
  logic [15:0] out_free_frames;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;

  int          idle_pct;
  int          quiet_cycles = 0;
  int unsigned frames_set;
  logic [19:0] held_frames [$];

  logic [15:0] phase_frames [PHASES] = '{16'd32768, 16'd100, 16'hFFFF, 16'd33, 16'd1,
                                         16'd1024, 16'd0, 16'd32, 16'd500};
  int          phase_idle   [PHASES] = '{0, 86, 29, 0, 86, 29, 0, 86, 29};

  bitmap_frame_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_address        (in_address),
    .in_size_bytes     (in_size_bytes),
    .out_valid         (out_valid),
    .out_frame_address (out_frame_address),
    .out_status        (out_status),
    .out_free_frames   (out_free_frames),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  frame_alloc_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_address        (in_address),
    .in_size_bytes     (in_size_bytes),
    .out_valid         (out_valid),
    .out_frame_address (out_frame_address),
    .out_status        (out_status),
    .out_free_frames   (out_free_frames),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1 || cfg_we === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Remember allocated frames so that frees can target them.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_frame_address != 0 && held_frames.size() < 512)
      held_frames.push_back(out_frame_address[31:12]);
  end

  task automatic send_op(logic [1:0] fn, logic [31:0] addr, logic [31:0] size);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= fn;
    in_address    <= addr;
    in_size_bytes <= size;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [15:0] value);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    frames_set = (value > MAX_FRAMES) ? MAX_FRAMES : value;
  endtask

  task automatic random_op();
    int unsigned win;
    int unsigned fr;
    int unsigned n;
    int unsigned pick;
    int          r;
    logic [31:0] addr;
    logic [31:0] size;
    if (frames_set == 0) win = 64;
    else if ($urandom_range(9) == 0 || frames_set < 256) win = frames_set;
    else win = 256;
    fr   = $urandom_range(win);
    addr = {fr[19:0], 12'($urandom)};
    r    = $urandom_range(99);
    if (r < 35) begin
      send_op(FN_ALLOC, $urandom, $urandom);
    end else if (r < 60) begin
      if (held_frames.size() != 0 && $urandom_range(9) < 6) begin
        pick = $urandom_range(held_frames.size() - 1);
        addr = {held_frames[pick], 12'($urandom)};
        held_frames.delete(pick);
      end else if ($urandom_range(9) == 0) begin
        addr = $urandom;
      end
      send_op(FN_FREE, addr, $urandom);
    end else begin
      n    = ($urandom_range(3) == 0) ? $urandom_range(200) : $urandom_range(24);
      size = {n[19:0], 12'($urandom)};
      if ($urandom_range(19) == 0) begin
        addr = $urandom;
        size = $urandom;
      end
      send_op((r < 82) ? FN_REG_FREE : FN_REG_USED, addr, size);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = FN_ALLOC;
    in_address    = '0;
    in_size_bytes = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    idle_pct      = 0;
    frames_set    = MAX_FRAMES;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // allocate with zero count, free paths, empty and overhanging regions
    send_op(FN_ALLOC, 32'h0, 32'h0);
    send_op(FN_FREE, 32'h0000_5000, 32'h0);
    send_op(FN_FREE, 32'h0000_5FFF, 32'h0);
    send_op(FN_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FN_ALLOC, $urandom, $urandom);
    send_op(FN_REG_USED, 32'h0000_7000, 32'h0000_0FFF);
    send_op(FN_REG_FREE, 32'h0000_9000, 32'h0);
    send_op(FN_REG_FREE, 32'h0, 32'(64) << FRAME_SHIFT);
    send_op(FN_ALLOC, 32'h0, 32'h0);
    send_op(FN_REG_FREE, 32'(MAX_FRAMES - 4) << FRAME_SHIFT, 32'(16) << FRAME_SHIFT);
    send_op(FN_REG_USED, 32'h0, 32'hFFFF_FFFF);
    send_op(FN_ALLOC, 32'h0, 32'h0);
    send_op(FN_REG_FREE, 32'h0, 32'hFFFF_F000);
    send_op(FN_ALLOC, 32'h0, 32'h0);
    send_op(FN_REG_USED, 32'h0, 32'(MAX_FRAMES - 1) << FRAME_SHIFT);
    // count is zero while the top frame is still clear
    send_op(FN_ALLOC, 32'h0, 32'h0);
    send_op(FN_FREE, 32'h0000_3000, 32'h0);
    send_op(FN_ALLOC, 32'h0, 32'h0);
    send_op(FN_FREE, 32'h07FF_F000, 32'h0);
    // clear frames exist only past the last whole word
    write_frame_count(16'd40);
    send_op(FN_REG_FREE, 32'(32) << FRAME_SHIFT, 32'(8) << FRAME_SHIFT);
    send_op(FN_ALLOC, 32'h0, 32'h0);
    write_frame_count(16'd0);
    send_op(FN_ALLOC, 32'h0, 32'h0);
    send_op(FN_FREE, 32'h0, 32'h0);
    send_op(FN_REG_FREE, 32'h0, 32'h0000_1000);
    write_frame_count(16'hFFFF);
    send_op(FN_REG_USED, 32'h07FF_F000, 32'h0000_1000);
    send_op(FN_FREE, 32'h07FF_FABC, 32'h0);
    send_op(FN_ALLOC, 32'h0, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      write_frame_count(phase_frames[p]);
      idle_pct = phase_idle[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_op();
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
